// File: rtl/psbp_pkg.sv
// ----------------------------------------------------------------------------
// psbp_pkg: shared types and constants of the scanline bit packer
// Widths of the pixel, byte and pending state, and the packer result bundle.
// ----------------------------------------------------------------------------
package psbp_pkg;

  localparam int PixelBits  = 16;
  localparam int ByteBits   = 8;
  localparam int WidthBits  = 5;
  localparam int PendBits   = 7;
  localparam int PendCntBits = 3;
  localparam int MaxBytes   = 3;
  localparam int CountBits  = 2;

  localparam logic [WidthBits-1:0] SampleBitsReset = 5'd16;
  localparam logic [WidthBits-1:0] ByteModeWidth   = 5'd8;

  // bytes produced by one pixel, plus the pending state it leaves behind
  typedef struct packed {
    logic [MaxBytes-1:0][ByteBits-1:0] bytes;
    logic [CountBits-1:0]              count;
    logic [PendBits-1:0]               pend_bits;
    logic [PendCntBits-1:0]            pend_count;
  } pack_res_t;

endpackage

// File: rtl/psbp_pack.sv
// ----------------------------------------------------------------------------
// psbp_pack: single-pass byte formation for one pixel
// Covers two-byte, eight-bit and MSB-first packed modes, with row-end flush.
// ----------------------------------------------------------------------------
module psbp_pack (
  input  logic [psbp_pkg::WidthBits-1:0]   sample_bits,
  input  logic [psbp_pkg::PixelBits-1:0]   pixel,
  input  logic                             row_end,
  input  logic [psbp_pkg::PendBits-1:0]    pend_bits,
  input  logic [psbp_pkg::PendCntBits-1:0] pend_count,
  output psbp_pkg::pack_res_t              res
);

  logic [3:0]  w4;
  logic [15:0] mask16;
  logic [15:0] masked;
  logic [22:0] acc;
  logic [4:0]  total;
  logic [2:0]  rem;
  logic [1:0]  nfull;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [6:0]  left;
  logic [7:0]  flush;

  assign w4     = sample_bits[3:0];
  assign mask16 = ~(16'hFFFF << w4);
  assign masked = pixel & mask16;
  assign acc    = ({16'd0, pend_bits} << w4) | {7'd0, masked};
  assign total  = {2'b00, pend_count} + {1'b0, w4};
  assign b0     = 8'(acc >> (total - 5'd8));
  assign b1     = 8'(acc >> (total - 5'd16));

  always_comb begin
    if (total >= 5'd16) begin
      nfull = 2'd2;
      rem   = 3'(total - 5'd16);
    end else if (total >= 5'd8) begin
      nfull = 2'd1;
      rem   = 3'(total - 5'd8);
    end else begin
      nfull = 2'd0;
      rem   = total[2:0];
    end
  end

  assign left  = acc[6:0] & ~(7'h7F << rem);
  assign flush = 8'({1'b0, left} << (4'd8 - {1'b0, rem}));

  always_comb begin
    res = '0;
    if (sample_bits[4]) begin
      // two-byte mode, low byte first; widths above sixteen land here too
      res.bytes[0] = pixel[7:0];
      res.bytes[1] = pixel[15:8];
      res.count    = 2'd2;
    end else if (sample_bits == psbp_pkg::ByteModeWidth) begin
      res.bytes[0] = pixel[9:2];
      res.count    = 2'd1;
    end else begin
      res.bytes[0] = b0;
      res.bytes[1] = b1;
      res.count    = nfull;
      if (row_end) begin
        if (rem != 3'd0) begin
          res.bytes[nfull] = flush;
          res.count        = nfull + 2'd1;
        end
      end else begin
        res.pend_bits  = left;
        res.pend_count = rem;
      end
    end
  end

endmodule

// File: rtl/pixel_scanline_bit_packer_core.sv
// ----------------------------------------------------------------------------
// pixel_scanline_bit_packer_core: pixel samples in, scanline bytes out
// Packs 16-bit pixels into bytes by the programmed sample width.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input channel: pixel and row_end qualified by in_valid; a word is taken
//    on a rising edge with in_valid high and in_stall low.
//  - Output channel: out_byte, row_last_byte and item_last qualified by
//    out_valid; the receiver holds out_stall high to pause it.
//  - cfg_we/cfg_data write sample_bits (reset 16). A write also drops any
//    part-packed bits of an unfinished row. Write only while idle.
//  - Each pixel yields zero to three bytes (two in 16-bit mode, one in 8-bit
//    mode, up to two full bytes plus a row-end flush in packed mode).
//  - The first byte of a pixel is on the output the cycle after
//    the pixel is taken.
//  - Pixel rate is set by the one-byte output port draining the three-entry
//    result register. The next pixel is taken in the same cycle the last
//    byte is handed over, or while the register is empty.
//  - A pixel that makes no byte (width zero, nothing pending) leaves the result register empty.
//  - While the receiver stalls, the held byte stays put; in_stall is high
//    whenever a byte is held, except in the cycle its last byte leaves.
//  - Reset (rst, synchronous): result register empty, pending bits cleared,
//    sample_bits back to 16.
// ----------------------------------------------------------------------------
module pixel_scanline_bit_packer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [psbp_pkg::WidthBits-1:0]        cfg_data,
  // pixel input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [psbp_pkg::PixelBits-1:0]        pixel,
  input  logic                                  row_end,
  // byte output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [psbp_pkg::ByteBits-1:0]         out_byte,
  output logic                                  row_last_byte,
  output logic                                  item_last
);

  // programmed width and leftover packed bits
  logic [psbp_pkg::WidthBits-1:0]   sample_bits;
  logic [psbp_pkg::PendBits-1:0]    pend_bits;
  logic [psbp_pkg::PendCntBits-1:0] pend_count;

  // result register: bytes of the current pixel, drained one per cycle while out_stall is low
  logic [psbp_pkg::MaxBytes-1:0][psbp_pkg::ByteBits-1:0] res_bytes;
  logic [psbp_pkg::CountBits-1:0] res_count;
  logic [psbp_pkg::CountBits-1:0] res_idx;
  logic                           res_row_end;

  psbp_pkg::pack_res_t pack_res;

  logic in_accept;
  logic out_take;
  logic last_byte;

  psbp_pack u_pack (
    .sample_bits (sample_bits),
    .pixel       (pixel),
    .row_end     (row_end),
    .pend_bits   (pend_bits),
    .pend_count  (pend_count),
    .res         (pack_res)
  );

  assign out_valid = (res_count != '0);
  assign last_byte = (res_idx == (res_count - 2'd1));
  assign out_take  = out_valid && !out_stall;

  // room for a new pixel once the register is empty or its last byte leaves
  assign in_stall  = out_valid && !(out_take && last_byte);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    case (res_idx)
      2'd0:    out_byte = res_bytes[0];
      2'd1:    out_byte = res_bytes[1];
      2'd2:    out_byte = res_bytes[2];
      default: out_byte = '0;
    endcase
  end

  assign item_last     = last_byte;
  assign row_last_byte = last_byte && res_row_end;

  // configuration and packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bits <= psbp_pkg::SampleBitsReset;
      pend_bits   <= '0;
      pend_count  <= '0;
    end else if (cfg_we) begin
      sample_bits <= cfg_data;
      pend_bits   <= '0;
      pend_count  <= '0;
    end else if (in_accept) begin
      pend_bits   <= pack_res.pend_bits;
      pend_count  <= pack_res.pend_count;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
      res_idx   <= '0;
    end else if (in_accept) begin
      res_count <= pack_res.count;
      res_idx   <= '0;
    end else if (out_take) begin
      if (last_byte) begin
        res_count <= '0;
        res_idx   <= '0;
      end else begin
        res_idx   <= res_idx + 2'd1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_bytes   <= pack_res.bytes;
      res_row_end <= row_end;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pixel_scanline_bit_packer_core
// Drives pixel words through the packer at several sample widths. A directed
// table comes first, followed by randomised rows of pixels. Every byte the
// block hands over is compared with a local model or with typed-in table bytes.
// ----------------------------------------------------------------------------
module testbench;

  // one expected output word
  typedef struct packed {
    logic [psbp_pkg::ByteBits-1:0] data;
    logic                          row_last;
    logic                          last;
  } byte_exp_t;

  // directed table row: either a width write, or a pixel word with its bytes
  // optionally typed in (typed = 1) rather than taken from the model
  typedef struct packed {
    logic                           cfg;
    logic [psbp_pkg::WidthBits-1:0] width;
    logic [psbp_pkg::PixelBits-1:0] pix;
    logic                           re;
    logic                           typed;
    logic [1:0]                     n;
    logic [psbp_pkg::ByteBits-1:0]  b0;
    logic [psbp_pkg::ByteBits-1:0]  b1;
  } dir_row_t;

  typedef logic [psbp_pkg::PixelBits-1:0] pix_t;

  localparam int DirRows     = 25;
  localparam int RandPhases  = 14;
  localparam int PhaseWords  = 24;
  localparam int SettleCycles = 4;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [psbp_pkg::WidthBits-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [psbp_pkg::PixelBits-1:0] pixel = '0;
  logic                           row_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [psbp_pkg::ByteBits-1:0]  out_byte;
  logic                           row_last_byte;
  logic                           item_last;

  // local copy of the packer state
  logic [psbp_pkg::WidthBits-1:0]   width_q = psbp_pkg::SampleBitsReset;
  logic [psbp_pkg::PendBits-1:0]    pend_bits = '0;
  logic [psbp_pkg::PendCntBits-1:0] pend_cnt = '0;

  byte_exp_t byte_q[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int fault_count   = 0;
  int bytes_checked = 0;
  int words_sent    = 0;
  int width_writes  = 0;

  dir_row_t dir_tab [DirRows];

  pixel_scanline_bit_packer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .row_end      (row_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .row_last_byte(row_last_byte),
    .item_last    (item_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Timeout: %0d bytes still awaited", byte_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Packer model. Works out the bytes for one accepted pixel word and moves
  // the pending state on; bytes are queued only when queue_it is set.
  function automatic void predict_bytes(input logic [psbp_pkg::PixelBits-1:0] p,
                                        input logic re, input bit queue_it);
    int unsigned                   acc;
    int unsigned                   total;
    int unsigned                   w;
    int                            n;
    logic [psbp_pkg::ByteBits-1:0] got [psbp_pkg::MaxBytes];
    byte_exp_t                     e;
    n = 0;
    w = 32'(width_q);
    if (w >= psbp_pkg::PixelBits) begin
      // two-byte mode, low byte first; widths above 16 land here too
      got[0] = p[7:0];
      got[1] = p[15:8];
      n = 2;
    end else if (w == psbp_pkg::ByteModeWidth) begin
      got[0] = p[9:2];
      n = 1;
    end else begin
      acc   = 32'(pend_bits);
      total = 32'(pend_cnt);
      if (w > 0) begin
        acc   = (acc << w) | (p & ((32'd1 << w) - 1));
        total += w;
      end
      while (total >= psbp_pkg::ByteBits) begin
        got[n] = 8'(acc >> (total - psbp_pkg::ByteBits));
        n++;
        total -= psbp_pkg::ByteBits;
      end
      acc &= (32'd1 << total) - 1;
      if (re) begin
        // flush leftover bits, zero padded on the right
        if (total > 0) begin
          got[n] = 8'(acc << (psbp_pkg::ByteBits - total));
          n++;
        end
        acc   = 0;
        total = 0;
      end
      pend_bits = acc[psbp_pkg::PendBits-1:0];
      pend_cnt  = total[psbp_pkg::PendCntBits-1:0];
    end
    if (queue_it) begin
      for (int i = 0; i < n; i++) begin
        e.data     = got[i];
        e.last     = (i == n - 1);
        e.row_last = re && (i == n - 1);
        byte_q.push_back(e);
      end
    end
  endfunction

  // Offers one pixel word and returns once it has been taken. Random idle
  // cycles go before the word; valid only drops when an idle cycle is taken.
  task automatic send_pixel(input logic [psbp_pkg::PixelBits-1:0] p, input logic re,
                            input bit queue_it);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    row_end  <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    predict_bytes(p, re, queue_it);
  endtask

  // Width write: only once the block has drained and a settling wait has passed,
  // for a word that makes no byte and may still be in flight.
  task automatic write_width(input logic [psbp_pkg::WidthBits-1:0] w);
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_q   = w;
    pend_bits = '0;
    pend_cnt  = '0;
    width_writes++;
  endtask

  // random receiver stall
  always @(posedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  // output checker: each handed-over byte against the oldest expectation
  always @(posedge clk) begin
    byte_exp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (byte_q.size() == 0) begin
        report_fault($sformatf("unexpected byte %02h row_last %0b last %0b",
                               out_byte, row_last_byte, item_last));
      end else begin
        want = byte_q.pop_front();
        bytes_checked++;
        if (out_byte !== want.data || row_last_byte !== want.row_last ||
            item_last !== want.last) begin
          report_fault($sformatf(
            "byte mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b (byte/row_last/last)",
            want.data, want.row_last, want.last, out_byte, row_last_byte, item_last));
        end
      end
    end
  end

  initial begin
    int                             row_left;
    int                             mode;
    logic                           re;
    logic [psbp_pkg::PixelBits-1:0] p;
    logic [psbp_pkg::WidthBits-1:0] w;
    byte_exp_t                      e;
    logic [psbp_pkg::WidthBits-1:0] edge_widths [8];

    // Directed rows. Fields: cfg, width, pixel, row_end, typed, count, b0, b1
    dir_tab = '{
      // reset width 16: two bytes, low first
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, 2'd2, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, 2'd2, 8'hFF, 8'hFF},
      '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b1, 2'd2, 8'h34, 8'h12},
      // byte mode takes bits 9..2 only
      '{1'b1, 5'd8,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h03FC, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00},
      '{1'b0, 5'd0,  16'hFC03, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00},
      // one bit per pixel, masked; row end flushes 111 as E0
      '{1'b1, 5'd1,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h0001, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h0003, 1'b1, 1'b1, 2'd1, 8'hE0, 8'h00},
      // width zero: a row end with nothing pending makes no byte
      '{1'b1, 5'd0,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      // widths above sixteen behave as sixteen
      '{1'b1, 5'd31, 16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hABCD, 1'b1, 1'b1, 2'd2, 8'hCD, 8'hAB},
      // width 15: second word gives two full bytes plus the flush
      '{1'b1, 5'd15, 16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h8001, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b1, 5'd7,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h007F, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'hFF80, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      // nibbles A then 5 make one whole byte, nothing left to flush
      '{1'b1, 5'd4,  16'h0000, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h000A, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{1'b0, 5'd0,  16'h0005, 1'b1, 1'b1, 2'd1, 8'hA5, 8'h00}
    };
    edge_widths = '{5'd16, 5'd8, 5'd0, 5'd1, 5'd31, 5'd15, 5'd2, 5'd7};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under light idling on both sides
    in_idle_pct   = 17;
    out_stall_pct = 17;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) begin
        write_width(dir_tab[i].width);
      end else begin
        send_pixel(dir_tab[i].pix, dir_tab[i].re, !dir_tab[i].typed);
        if (dir_tab[i].typed) begin
          for (int k = 0; k < dir_tab[i].n; k++) begin
            e.data     = (k == 0) ? dir_tab[i].b0 : dir_tab[i].b1;
            e.last     = (k == dir_tab[i].n - 1);
            e.row_last = dir_tab[i].re && (k == dir_tab[i].n - 1);
            byte_q.push_back(e);
          end
        end
      end
    end

    // random part: one width per phase, rows of random length; idling
    // cycles through none / sender only / receiver only / both
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph < 8) w = edge_widths[ph];
      else if ($urandom_range(1) == 0) w = 5'($urandom_range(1, 15));
      else w = 5'($urandom_range(0, 31));
      write_width(w);
      mode = ph % 4;
      in_idle_pct   = (mode == 1) ? 68 : (mode == 3) ? 17 : 0;
      out_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 17 : 0;
      row_left = $urandom_range(1, 8);
      for (int j = 0; j < PhaseWords; j++) begin
        case ($urandom_range(7))
          0: begin
            p = '0;
          end
          1: begin
            p = '1;
          end
          default: begin
            p = pix_t'($urandom);
          end
        endcase
        row_left--;
        re = (row_left == 0);
        if (re) row_left = $urandom_range(1, 8);
        send_pixel(p, re, 1'b1);
      end
    end

    // drain, then keep watching for stray bytes
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SettleCycles * 4) @(posedge clk);

    $display("Summary: %0d pixel words over %0d width writes, %0d bytes compared",
             words_sent, width_writes, bytes_checked);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d faults in total", fault_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
